// ----- hdl/lsps_pkg.sv -----
package lsps_pkg;

   localparam int INTEGRAL_WIDTH_DEF = 24;

   localparam int SENSOR_W  = 8;
   localparam int BIAS_W    = 6;
   localparam int DELTA_W   = BIAS_W + 1;
   localparam int ZONE_W    = 3;
   localparam int GAIN_W    = 16;
   localparam int BASE_W    = 8;
   localparam int DRIVE_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Zone codes.
   localparam logic [ZONE_W-1:0] ZONE_NONE    = 3'd0;
   localparam logic [ZONE_W-1:0] ZONE_CENTRED = 3'd1;
   localparam logic [ZONE_W-1:0] ZONE_SMALL   = 3'd2;
   localparam logic [ZONE_W-1:0] ZONE_MEDIUM  = 3'd3;
   localparam logic [ZONE_W-1:0] ZONE_LARGE   = 3'd4;
   localparam logic [ZONE_W-1:0] ZONE_STOP    = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 2'd3;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd26;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;
   localparam logic [BASE_W-1:0]        BASE_SPEED_RST = 8'd50;

   localparam logic [SENSOR_W-1:0] PAT_ALL_ON = 8'hFF;

   typedef struct packed {
      logic                     hit;
      logic signed [BIAS_W-1:0] bias;
      logic [ZONE_W-1:0]        zone;
   } pat_entry_type;

   // Off-center patterns, bias in half-units.
   function automatic pat_entry_type pat_lookup(input logic [SENSOR_W-1:0] s);
      pat_entry_type e;
      e = '{hit: 1'b1, bias: '0, zone: ZONE_NONE};
      case (s)
         8'hF3:   begin e.bias = -6'sd4;  e.zone = ZONE_SMALL;  end
         8'hFB:   begin e.bias = -6'sd6;  e.zone = ZONE_SMALL;  end
         8'hCF:   begin e.bias = 6'sd4;   e.zone = ZONE_SMALL;  end
         8'hDF:   begin e.bias = 6'sd6;   e.zone = ZONE_SMALL;  end
         8'hF9:   begin e.bias = -6'sd7;  e.zone = ZONE_MEDIUM; end
         8'hFD:   begin e.bias = -6'sd8;  e.zone = ZONE_MEDIUM; end
         8'h9F:   begin e.bias = 6'sd7;   e.zone = ZONE_MEDIUM; end
         8'hBF:   begin e.bias = 6'sd8;   e.zone = ZONE_MEDIUM; end
         8'h3F:   begin e.bias = 6'sd13;  e.zone = ZONE_LARGE;  end
         8'h7F:   begin e.bias = 6'sd20;  e.zone = ZONE_LARGE;  end
         8'hFC:   begin e.bias = -6'sd13; e.zone = ZONE_LARGE;  end
         8'hFE:   begin e.bias = -6'sd20; e.zone = ZONE_LARGE;  end
         default: e.hit = 1'b0;
      endcase
      return e;
   endfunction

endpackage

// ----- hdl/line_sensor_pid_steering.sv -----
// An accepted sensor item reaches its result on rsp_ through the registered stages named below.
// Throughput: one item per cycle; the decode/integral, multiply and
// round/saturate stages each hold one item and advance whenever downstream frees.
// Reset (synchronous, active high) empties the pipeline, clears the integral,
// held bias, previous bias and zone, and loads the default gains and base speed.
module line_sensor_pid_steering #(
   parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsps_pkg::SENSOR_W-1:0]       req_sensor_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lsps_pkg::DRIVE_W-1:0] rsp_left_drive,
   output logic signed [lsps_pkg::DRIVE_W-1:0] rsp_right_drive,
   output logic [lsps_pkg::ZONE_W-1:0]         rsp_zone,
   output logic                                rsp_motors_off,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsps_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import lsps_pkg::*;

   logic signed [GAIN_W-1:0] prop_gain_ff;
   logic signed [GAIN_W-1:0] integ_gain_ff;
   logic signed [GAIN_W-1:0] deriv_gain_ff;
   logic [BASE_W-1:0]        base_speed_ff;

   logic                              trk_valid, trk_ready;
   logic signed [BIAS_W-1:0]          trk_bias;
   logic signed [INTEGRAL_WIDTH-1:0]  trk_integral;
   logic signed [DELTA_W-1:0]         trk_delta;
   logic [ZONE_W-1:0]                 trk_zone;

   logic                                     mul_valid, mul_ready;
   logic signed [GAIN_W+BIAS_W-1:0]          mul_p;
   logic signed [GAIN_W+INTEGRAL_WIDTH-1:0]  mul_i;
   logic signed [GAIN_W+DELTA_W-1:0]         mul_d;
   logic [ZONE_W-1:0]                        mul_zone;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         base_speed_ff <= BASE_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            CSR_BASE_SPEED: base_speed_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   lsps_track #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_track (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .sensor_bits  (req_sensor_bits),
      .out_valid    (trk_valid),
      .out_ready    (trk_ready),
      .out_bias     (trk_bias),
      .out_integral (trk_integral),
      .out_delta    (trk_delta),
      .out_zone     (trk_zone)
   );

   lsps_mult #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (trk_valid),
      .in_ready   (trk_ready),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .bias       (trk_bias),
      .integral   (trk_integral),
      .delta      (trk_delta),
      .zone       (trk_zone),
      .out_valid  (mul_valid),
      .out_ready  (mul_ready),
      .out_p      (mul_p),
      .out_i      (mul_i),
      .out_d      (mul_d),
      .out_zone   (mul_zone)
   );

   lsps_drive #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_drive (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mul_valid),
      .in_ready    (mul_ready),
      .base_speed  (base_speed_ff),
      .p           (mul_p),
      .i           (mul_i),
      .d           (mul_d),
      .zone        (mul_zone),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .left_drive  (rsp_left_drive),
      .right_drive (rsp_right_drive),
      .out_zone    (rsp_zone),
      .motors_off  (rsp_motors_off)
   );

endmodule

// ----- hdl/lsps_track.sv -----
module lsps_track #(
   parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [lsps_pkg::SENSOR_W-1:0]         sensor_bits,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [lsps_pkg::BIAS_W-1:0]    out_bias,
   output logic signed [INTEGRAL_WIDTH-1:0]      out_integral,
   output logic signed [lsps_pkg::DELTA_W-1:0]   out_delta,
   output logic [lsps_pkg::ZONE_W-1:0]           out_zone
);
   import lsps_pkg::*;

   localparam int W = INTEGRAL_WIDTH;

   logic                       accept;
   pat_entry_type              entry;
   logic                       centre;
   logic                       all_on;
   logic                       active;
   logic signed [BIAS_W-1:0]   bias_new;
   logic [ZONE_W-1:0]          zone_new;
   logic signed [W-1:0]        integ_base;
   logic signed [W:0]          integ_sum;
   logic signed [W-1:0]        integ_sat;

   logic signed [W-1:0]        integral_ff, integral_in;
   logic signed [BIAS_W-1:0]   held_bias_ff, held_bias_in;
   logic signed [BIAS_W-1:0]   prev_bias_ff, prev_bias_in;
   logic [ZONE_W-1:0]          held_zone_ff, held_zone_in;

   logic                       valid_ff, valid_in;
   logic signed [BIAS_W-1:0]   bias_ff;
   logic signed [W-1:0]        integ_ff;
   logic signed [DELTA_W-1:0]  delta_ff;
   logic [ZONE_W-1:0]          zone_ff;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      entry  = pat_lookup(sensor_bits);
      centre = (sensor_bits[4:3] == 2'b00);
      all_on = (sensor_bits == PAT_ALL_ON);

      if (centre) begin
         bias_new = '0;
         zone_new = ZONE_CENTRED;
      end else if (all_on) begin
         bias_new = held_bias_ff;
         zone_new = ZONE_STOP;
      end else if (entry.hit) begin
         bias_new = entry.bias;
         zone_new = entry.zone;
      end else begin
         bias_new = held_bias_ff;
         zone_new = held_zone_ff;
      end

      active     = (zone_new != ZONE_STOP);
      integ_base = (centre || all_on) ? '0 : integral_ff;
      integ_sum  = {integ_base[W-1], integ_base}
                 + {{(W + 1 - BIAS_W){bias_new[BIAS_W-1]}}, bias_new};

      // One overflow bit is enough: the bias is far smaller than the range.
      if (integ_sum[W] != integ_sum[W-1]) begin
         integ_sat = integ_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[W-1:0];
      end

      integral_in  = active ? integ_sat : integ_base;
      prev_bias_in = active ? bias_new : prev_bias_ff;
      held_bias_in = bias_new;
      held_zone_in = zone_new;
      valid_in     = accept ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         held_bias_ff <= '0;
         prev_bias_ff <= '0;
         held_zone_ff <= ZONE_NONE;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            integral_ff  <= integral_in;
            held_bias_ff <= held_bias_in;
            prev_bias_ff <= prev_bias_in;
            held_zone_ff <= held_zone_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bias_ff  <= bias_new;
         integ_ff <= integral_in;
         delta_ff <= {bias_new[BIAS_W-1], bias_new} - {prev_bias_ff[BIAS_W-1], prev_bias_ff};
         zone_ff  <= zone_new;
      end
   end

   assign out_valid    = valid_ff;
   assign out_bias     = bias_ff;
   assign out_integral = integ_ff;
   assign out_delta    = delta_ff;
   assign out_zone     = zone_ff;

endmodule

// ----- hdl/lsps_mult.sv -----
module lsps_mult #(
   parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic signed [lsps_pkg::GAIN_W-1:0]         prop_gain,
   input  logic signed [lsps_pkg::GAIN_W-1:0]         integ_gain,
   input  logic signed [lsps_pkg::GAIN_W-1:0]         deriv_gain,
   input  logic signed [lsps_pkg::BIAS_W-1:0]         bias,
   input  logic signed [INTEGRAL_WIDTH-1:0]           integral,
   input  logic signed [lsps_pkg::DELTA_W-1:0]        delta,
   input  logic [lsps_pkg::ZONE_W-1:0]                zone,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic signed [lsps_pkg::GAIN_W+lsps_pkg::BIAS_W-1:0]  out_p,
   output logic signed [lsps_pkg::GAIN_W+INTEGRAL_WIDTH-1:0]    out_i,
   output logic signed [lsps_pkg::GAIN_W+lsps_pkg::DELTA_W-1:0] out_d,
   output logic [lsps_pkg::ZONE_W-1:0]                out_zone
);
   import lsps_pkg::*;

   localparam int PW = GAIN_W + BIAS_W;
   localparam int IW = GAIN_W + INTEGRAL_WIDTH;
   localparam int DW = GAIN_W + DELTA_W;

   logic                 accept;
   logic                 valid_ff, valid_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic signed [IW-1:0] i_ff, i_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic [ZONE_W-1:0]    zone_ff;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      p_in     = prop_gain * bias;
      i_in     = integ_gain * integral;
      d_in     = deriv_gain * delta;
      valid_in = accept ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff    <= p_in;
         i_ff    <= i_in;
         d_ff    <= d_in;
         zone_ff <= zone;
      end
   end

   assign out_valid = valid_ff;
   assign out_p     = p_ff;
   assign out_i     = i_ff;
   assign out_d     = d_ff;
   assign out_zone  = zone_ff;

endmodule

// ----- hdl/lsps_drive.sv -----
module lsps_drive #(
   parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [lsps_pkg::BASE_W-1:0]                base_speed,
   input  logic signed [lsps_pkg::GAIN_W+lsps_pkg::BIAS_W-1:0]  p,
   input  logic signed [lsps_pkg::GAIN_W+INTEGRAL_WIDTH-1:0]    i,
   input  logic signed [lsps_pkg::GAIN_W+lsps_pkg::DELTA_W-1:0] d,
   input  logic [lsps_pkg::ZONE_W-1:0]                zone,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic signed [lsps_pkg::DRIVE_W-1:0]        left_drive,
   output logic signed [lsps_pkg::DRIVE_W-1:0]        right_drive,
   output logic [lsps_pkg::ZONE_W-1:0]                out_zone,
   output logic                                       motors_off
);
   import lsps_pkg::*;

   localparam int PW = GAIN_W + BIAS_W;
   localparam int IW = GAIN_W + INTEGRAL_WIDTH;
   localparam int DW = GAIN_W + DELTA_W;
   localparam int SW = INTEGRAL_WIDTH + GAIN_W + 2;
   localparam int FW = SW + 1;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

   logic                      accept;
   logic                      stop;
   logic signed [SW-1:0]      sum;
   logic signed [SW-1:0]      pid;
   logic signed [FW-1:0]      base_ext;
   logic signed [FW-1:0]      pid_ext;
   logic signed [FW-1:0]      left_full;
   logic signed [FW-1:0]      right_full;
   logic signed [DRIVE_W-1:0] left_sat;
   logic signed [DRIVE_W-1:0] right_sat;

   logic                      valid_ff, valid_in;
   logic signed [DRIVE_W-1:0] left_ff, left_in;
   logic signed [DRIVE_W-1:0] right_ff, right_in;
   logic [ZONE_W-1:0]         zone_ff;
   logic                      off_ff, off_in;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      // Products carry nine fraction bits; adding one and halving rounds half up.
      sum = {{(SW-PW){p[PW-1]}}, p} + {{(SW-IW){i[IW-1]}}, i}
          + {{(SW-DW){d[DW-1]}}, d} + SW'(1);
      pid = sum >>> 1;

      base_ext   = {{(FW-BASE_W-8){1'b0}}, base_speed, 8'h00};
      pid_ext    = {pid[SW-1], pid};
      left_full  = -(base_ext + pid_ext);
      right_full = base_ext - pid_ext;

      if (left_full > FW'(DRIVE_MAX)) begin
         left_sat = DRIVE_MAX;
      end else if (left_full < FW'(DRIVE_MIN)) begin
         left_sat = DRIVE_MIN;
      end else begin
         left_sat = left_full[DRIVE_W-1:0];
      end

      if (right_full > FW'(DRIVE_MAX)) begin
         right_sat = DRIVE_MAX;
      end else if (right_full < FW'(DRIVE_MIN)) begin
         right_sat = DRIVE_MIN;
      end else begin
         right_sat = right_full[DRIVE_W-1:0];
      end

      stop     = (zone == ZONE_STOP);
      left_in  = stop ? '0 : left_sat;
      right_in = stop ? '0 : right_sat;
      off_in   = stop;
      valid_in = accept ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         zone_ff  <= zone;
         off_ff   <= off_in;
      end
   end

   assign out_valid   = valid_ff;
   assign left_drive  = left_ff;
   assign right_drive = right_ff;
   assign out_zone    = zone_ff;
   assign motors_off  = off_ff;

endmodule

// ----- hdl/lsps_checker.sv -----
module lsps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lsps_pkg::DRIVE_W-1:0] rsp_left_drive,
   input logic signed [lsps_pkg::DRIVE_W-1:0] rsp_right_drive,
   input logic [lsps_pkg::ZONE_W-1:0]         rsp_zone,
   input logic                                rsp_motors_off
);
   import lsps_pkg::*;

   // A stopped result always carries zero drive on both wheels.
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motors_off |->
         rsp_zone == ZONE_STOP && rsp_left_drive == '0 && rsp_right_drive == '0)
      else $error("stopped item with nonzero drive or wrong zone");

   // Motors are off exactly in the stopped zone.
   a_stop_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zone == ZONE_STOP |-> rsp_motors_off)
      else $error("stopped zone without motors_off");

   // After reset, no item reaches the output until it has passed through the emptied pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result appeared too soon after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_zone))
      else $error("result changed while stalled");

   // Input is taken whenever the whole pipeline can drain.
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled with output side ready");

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (.*);

// ----- tb/line_sensor_pid_steering_tb.sv -----
module line_sensor_pid_steering_tb;
   import lsps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  INTEG_W      = INTEGRAL_WIDTH_DEF;
   localparam int  LIMIT_CYCLES = 4_000_000;
   localparam int  SETTLE       = 8;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left;
      logic signed [DRIVE_W-1:0] right;
      logic [ZONE_W-1:0]         zone;
      logic                      off;
   } drive_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SENSOR_W-1:0]  req_sensor_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_left_drive;
   logic signed [DRIVE_W-1:0] rsp_right_drive;
   logic [ZONE_W-1:0]    rsp_zone;
   logic                 rsp_motors_off;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Predictor state and register copies.
   longint                    integ_acc;
   logic signed [BIAS_W-1:0]  bias_hold;
   logic signed [BIAS_W-1:0]  bias_last;
   logic [ZONE_W-1:0]         zone_hold;
   logic signed [GAIN_W-1:0]  kp, ki, kd;
   logic [BASE_W-1:0]         base_level;

   drive_cmd_type drive_expected[$];
   int         mismatches = 0;
   int         results_seen = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         hold_len = 0;
   int         hold_left = 0;

   logic [SENSOR_W-1:0] line_pats [12] = '{8'hF3, 8'hFB, 8'hCF, 8'hDF, 8'hF9, 8'hFD,
                                            8'h9F, 8'hBF, 8'h3F, 8'h7F, 8'hFC, 8'hFE};

   line_sensor_pid_steering #(.INTEGRAL_WIDTH(INTEG_W)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sensor_bits (req_sensor_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_zone        (rsp_zone),
      .rsp_motors_off  (rsp_motors_off),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic void clear_steering_state();
      integ_acc  = 0;
      bias_hold  = '0;
      bias_last  = '0;
      zone_hold  = ZONE_NONE;
      kp         = PROP_GAIN_RST;
      ki         = INTEG_GAIN_RST;
      kd         = DERIV_GAIN_RST;
      base_level = BASE_SPEED_RST;
   endfunction

   // Advances the steering state by one sensor item and returns the wheel commands.
   function automatic drive_cmd_type predict_drive(input logic [SENSOR_W-1:0] s);
      drive_cmd_type cmd;
      longint     ilim, sum, pid, base_q8;
      ilim = longint'(1) << (INTEG_W - 1);
      if (s[4:3] == 2'b00) begin
         bias_hold = '0;
         zone_hold = ZONE_CENTRED;
         integ_acc = 0;
      end else if (s == PAT_ALL_ON) begin
         zone_hold = ZONE_STOP;
         integ_acc = 0;
      end else begin
         case (s)
            8'hF3: begin bias_hold = -6'sd4;  zone_hold = ZONE_SMALL;  end
            8'hFB: begin bias_hold = -6'sd6;  zone_hold = ZONE_SMALL;  end
            8'hCF: begin bias_hold = 6'sd4;   zone_hold = ZONE_SMALL;  end
            8'hDF: begin bias_hold = 6'sd6;   zone_hold = ZONE_SMALL;  end
            8'hF9: begin bias_hold = -6'sd7;  zone_hold = ZONE_MEDIUM; end
            8'hFD: begin bias_hold = -6'sd8;  zone_hold = ZONE_MEDIUM; end
            8'h9F: begin bias_hold = 6'sd7;   zone_hold = ZONE_MEDIUM; end
            8'hBF: begin bias_hold = 6'sd8;   zone_hold = ZONE_MEDIUM; end
            8'h3F: begin bias_hold = 6'sd13;  zone_hold = ZONE_LARGE;  end
            8'h7F: begin bias_hold = 6'sd20;  zone_hold = ZONE_LARGE;  end
            8'hFC: begin bias_hold = -6'sd13; zone_hold = ZONE_LARGE;  end
            8'hFE: begin bias_hold = -6'sd20; zone_hold = ZONE_LARGE;  end
            default: ;
         endcase
      end
      cmd = '0;
      if (zone_hold != ZONE_STOP) begin
         integ_acc = clip(integ_acc + longint'(bias_hold), -ilim, ilim - 1);
         sum = longint'(kp) * longint'(bias_hold) + longint'(ki) * integ_acc
             + longint'(kd) * (longint'(bias_hold) - longint'(bias_last));
         bias_last = bias_hold;
         // Nine fraction bits down to eight, rounding half up.
         pid = (sum + 1) >>> 1;
         base_q8 = longint'(base_level) * 256;
         cmd.left  = DRIVE_W'(clip(-(base_q8 + pid), -8388608, 8388607));
         cmd.right = DRIVE_W'(clip(base_q8 - pid, -8388608, 8388607));
      end
      cmd.zone = zone_hold;
      cmd.off  = (zone_hold == ZONE_STOP);
      return cmd;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_seen++;
         if (drive_expected.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = drive_expected.pop_front();
            if (rsp_left_drive !== want.left || rsp_right_drive !== want.right ||
                rsp_zone !== want.zone || rsp_motors_off !== want.off)
               flag_mismatch($sformatf(
                  "result %0d: left %0d/%0d right %0d/%0d zone %0d/%0d off %0b/%0b (exp/got)",
                  results_seen, $signed(want.left), rsp_left_drive, $signed(want.right),
                  rsp_right_drive, want.zone, rsp_zone, want.off, rsp_motors_off));
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_sensor(input logic [SENSOR_W-1:0] pattern);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_bits <= pattern;
      do @(posedge clock); while (req_ready !== 1'b1);
      drive_expected.push_back(predict_drive(pattern));
      @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (drive_expected.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PROP_GAIN:  kp = data;
         CSR_INTEG_GAIN: ki = data;
         CSR_DERIV_GAIN: kd = data;
         CSR_BASE_SPEED: base_level = data[BASE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_regs(input logic [15:0] p, input logic [15:0] i,
                                 input logic [15:0] d, input logic [7:0] b);
      write_reg(CSR_PROP_GAIN, p);
      write_reg(CSR_INTEG_GAIN, i);
      write_reg(CSR_DERIV_GAIN, d);
      write_reg(CSR_BASE_SPEED, {8'h00, b});
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom_range(0, 1023) - 512);
      endcase
   endfunction

   function automatic logic [7:0] pick_base();
      case ($urandom_range(3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Line positions the table knows half the time, with centred, all-on and noise mixed in.
   function automatic logic [SENSOR_W-1:0] pick_pattern();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return line_pats[$urandom_range(11)];
         5:             return 8'($urandom_range(255)) & 8'hE7;
         6:             return PAT_ALL_ON;
         default:       return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_table_walk();
      logic [SENSOR_W-1:0] walk [20] = '{8'hF3, 8'hFB, 8'hCF, 8'hDF, 8'hF9, 8'hFD, 8'h9F,
                                          8'hBF, 8'h3F, 8'h7F, 8'hAA, 8'hFC, 8'hFE, 8'hFF,
                                          8'h5A, 8'hFE, 8'h00, 8'hFF, 8'hE7, 8'h18};
      send_idle_pct = 0;
      stall_pct     = 0;
      // Unlisted pattern before any line was seen, then centred, with reset gains.
      send_sensor(8'h55);
      send_sensor(8'hE7);
      wait_results_done();
      write_all_regs(16'h0100, 16'h0040, 16'h0080, 8'd100);
      foreach (walk[k]) send_sensor(walk[k]);
      wait_results_done();
   endtask

   task automatic test_register_extremes();
      logic [15:0] gains [3] = '{16'h7FFF, 16'h8000, 16'h0000};
      send_idle_pct = 20;
      stall_pct     = 20;
      foreach (gains[g]) begin
         write_all_regs(gains[g], gains[(g + 1) % 3], gains[(g + 2) % 3],
                        (g == 0) ? 8'd255 : 8'd0);
         send_sensor(8'h00);
         send_sensor(8'h7F);
         send_sensor(8'hFE);
         send_sensor(8'h66);
         send_sensor(8'hFC);
         send_sensor(8'hFF);
         wait_results_done();
      end
   endtask

   task automatic test_integral_windup();
      int runs;
      runs = 60;
      send_idle_pct = 0;
      stall_pct     = 0;
      write_all_regs(16'h0000, 16'h0001, 16'h0000, 8'd0);
      send_sensor(8'h00);
      repeat (runs) send_sensor(8'h7F);
      wait_results_done();
      // With a large integral, full-scale gains drive both commands to the rails.
      write_reg(CSR_INTEG_GAIN, 16'h7FFF);
      send_sensor(8'h7F);
      send_sensor(8'h99);
      wait_results_done();
      write_reg(CSR_INTEG_GAIN, 16'h8000);
      send_sensor(8'h7F);
      send_sensor(8'hFE);
      wait_results_done();
      write_reg(CSR_INTEG_GAIN, 16'h0001);
      send_sensor(8'h00);
      repeat (runs) send_sensor(8'hFE);
      send_sensor(8'h7F);
      wait_results_done();
   endtask

   task automatic test_backpressure_fill();
      write_all_regs(pick_gain(), pick_gain(), pick_gain(), pick_base());
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_len      = 300;
      repeat (40) send_sensor(pick_pattern());
      // Sender rests until every result has drained.
      wait_results_done();
   endtask

   task automatic test_random_traffic();
      int idle_mix  [4] = '{0, 85, 0, 23};
      int stall_mix [4] = '{0, 0, 85, 23};
      foreach (idle_mix[ph]) begin
         write_all_regs(pick_gain(), pick_gain(), pick_gain(), pick_base());
         send_idle_pct = idle_mix[ph];
         stall_pct     = stall_mix[ph];
         repeat (240) send_sensor(pick_pattern());
         wait_results_done();
      end
   endtask

   initial begin
      clear_steering_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_table_walk();
      test_register_extremes();
      test_integral_windup();
      test_backpressure_fill();
      test_random_traffic();
      wait_results_done();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
